@@ rtl/crce_pkg.sv @@
// ----------------------------------------------------------------------------
// crce_pkg
// Shared types, constants and the byte-wise CRC step of the CRC engine.
// ----------------------------------------------------------------------------
`default_nettype none

package crce_pkg;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// configuration register indexes
	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_POLY   = 2'd2;

	// request function codes
	localparam logic FUNC_DATA   = 1'b0;
	localparam logic FUNC_LENGTH = 1'b1;

	// maximum number of bytes in one word
	localparam logic [2:0] MAX_BYTES = 3'd4;

	typedef enum logic [1:0] {
		WM_CRC8  = 2'd0,
		WM_CRC16 = 2'd1,
		WM_CRC32 = 2'd2,
		WM_RSVD  = 2'd3
	} width_mode_t;

	// one classified conversion, crc and polynomial left-aligned to bit 31
	typedef struct packed {
		logic        run;
		logic        raised;
		width_mode_t mode;
		logic [2:0]  count;
		logic [31:0] word;
		logic [31:0] poly_al;
		logic [31:0] init_al;
	} cmd_t;

	// one message byte through eight msb-first shift steps
	function automatic logic [31:0] crc_byte_step(input logic [31:0] crc,
			input logic [7:0] data_byte, input logic [31:0] poly_al);
		logic [31:0] c;
		c = crc ^ {data_byte, 24'h000000};
		for (int i = 0; i < 8; i++) begin
			c = c[31] ? ({c[30:0], 1'b0} ^ poly_al) : {c[30:0], 1'b0};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

@@ rtl/crce_if.sv @@
// ----------------------------------------------------------------------------
// crce_if
// Request and response channels of the CRC engine, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface crce_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] data_word;
	logic [2:0]  byte_count;

	modport source(output valid, output func, output data_word, output byte_count,
		input ready);
	modport sink(input valid, input func, input data_word, input byte_count,
		output ready);
endinterface

interface crce_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] crc_value;
	logic        accepted;
	logic        irq_raised;

	modport source(output valid, output crc_value, output accepted, output irq_raised,
		input ready);
	modport sink(input valid, input crc_value, input accepted, input irq_raised,
		output ready);
endinterface

`default_nettype wire

@@ rtl/crce_front.sv @@
// ----------------------------------------------------------------------------
// crce_front
// Holds configuration, data buffer and interrupt flag; classifies each
// request beat into a conversion command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module crce_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	crce_req_if.sink              req,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [31:0]      cfg_wdata,
	output crce_pkg::cmd_t        push_data,
	output logic                  push_valid,
	input  wire logic             push_ready
);
	import crce_pkg::*;

	logic        enable_q;
	width_mode_t mode_q;
	logic [31:0] poly_q;
	logic [31:0] buf_q;
	logic        irq_q;
	logic        irq_clear;
	logic        push_fire;
	logic        run;
	logic [2:0]  count_sat;

	assign push_valid = req.valid;
	assign req.ready  = push_ready;
	assign push_fire  = req.valid && push_ready;

	// control register writes clear the pending interrupt
	assign irq_clear = cfg_we && (cfg_index == REG_ENABLE || cfg_index == REG_WIDTH);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			mode_q   <= WM_CRC8;
			poly_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_wdata[0];
				REG_WIDTH:  mode_q   <= width_mode_t'(cfg_wdata[1:0]);
				REG_POLY:   poly_q   <= cfg_wdata;
				default:    ;
			endcase
		end
	end

	// data buffer, loaded by data write beats
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q <= '0;
		end else if (push_fire && req.func == FUNC_DATA) begin
			buf_q <= req.data_word;
		end
	end

	// classification
	assign run       = enable_q && (mode_q != WM_RSVD);
	assign count_sat = (req.byte_count > MAX_BYTES) ? MAX_BYTES : req.byte_count;

	always_comb begin
		push_data.run    = run;
		push_data.raised = run && !irq_q;
		push_data.mode   = mode_q;
		push_data.count  = count_sat;
		push_data.word   = (req.func == FUNC_DATA) ? req.data_word : buf_q;
		unique case (mode_q)
			WM_CRC8: begin
				push_data.poly_al = {poly_q[7:0], 24'h000000};
				push_data.init_al = 32'h0000_0000;
			end
			WM_CRC16: begin
				push_data.poly_al = {poly_q[15:0], 16'h0000};
				push_data.init_al = 32'hFFFF_0000;
			end
			WM_CRC32: begin
				push_data.poly_al = poly_q;
				push_data.init_al = 32'hFFFF_FFFF;
			end
			default: begin
				push_data.poly_al = '0;
				push_data.init_al = '0;
			end
		endcase
	end

	// sticky interrupt flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q <= 1'b0;
		end else if (irq_clear) begin
			irq_q <= 1'b0;
		end else if (push_fire && run) begin
			irq_q <= 1'b1;
		end
	end

	// a raised interrupt is only reported when none was pending
	assert property (@(posedge clk) disable iff (!arst_n)
		push_fire && push_data.raised |-> !irq_q)
		else $error("interrupt reported raised while already pending");

	// pending flag only drops on a control write
	assert property (@(posedge clk) disable iff (!arst_n)
		irq_q && !irq_clear |=> irq_q)
		else $error("pending interrupt lost without control write");

endmodule

`default_nettype wire

@@ rtl/crce_queue.sv @@
// ----------------------------------------------------------------------------
// crce_queue
// Small fifo of conversion commands between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module crce_queue #(
	parameter int DEPTH = crce_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire crce_pkg::cmd_t   push_data,
	input  wire logic             push_valid,
	output logic                  push_ready,
	output crce_pkg::cmd_t        pop_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready
);
	import crce_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          push_fire;
	logic          pop_fire;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;
	assign pop_data   = mem_q[rptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push_fire) begin
			mem_q[wptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push_fire) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (pop_fire) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + CW'(1);
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// fill count never exceeds the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue fill count above depth");

	// an empty queue has its pointers together
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q == '0 |-> wptr_q == rptr_q)
		else $error("queue pointers apart while empty");

endmodule

`default_nettype wire

@@ rtl/crce_back.sv @@
// ----------------------------------------------------------------------------
// crce_back
// Four-stage crc pipeline, one message byte per stage, with final
// alignment and reject handling on the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module crce_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire crce_pkg::cmd_t   pop_data,
	input  wire logic             pop_valid,
	output logic                  pop_ready,
	crce_rsp_if.source            rsp
);
	import crce_pkg::*;

	logic        adv;
	logic        v_s1, v_s2, v_s3, v_s4;
	cmd_t        cmd_s1, cmd_s2, cmd_s3, cmd_s4;
	logic [31:0] crc_s1, crc_s2, crc_s3, crc_s4;
	logic [31:0] crc_n0, crc_n1, crc_n2, crc_n3;

	// whole pipeline moves when the last stage is free or drained
	assign adv       = !v_s4 || rsp.ready;
	assign pop_ready = adv;

	// byte steps, each only if the byte count reaches it
	assign crc_n0 = (pop_data.count > 3'd0)
		? crc_byte_step(pop_data.init_al, pop_data.word[7:0], pop_data.poly_al)
		: pop_data.init_al;
	assign crc_n1 = (cmd_s1.count > 3'd1)
		? crc_byte_step(crc_s1, cmd_s1.word[15:8], cmd_s1.poly_al) : crc_s1;
	assign crc_n2 = (cmd_s2.count > 3'd2)
		? crc_byte_step(crc_s2, cmd_s2.word[23:16], cmd_s2.poly_al) : crc_s2;
	assign crc_n3 = (cmd_s3.count > 3'd3)
		? crc_byte_step(crc_s3, cmd_s3.word[31:24], cmd_s3.poly_al) : crc_s3;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pop_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= pop_data;
			crc_s1 <= crc_n0;
			cmd_s2 <= cmd_s1;
			crc_s2 <= crc_n1;
			cmd_s3 <= cmd_s2;
			crc_s3 <= crc_n2;
			cmd_s4 <= cmd_s3;
			crc_s4 <= crc_n3;
		end
	end

	// response beat, crc moved back down to its width
	assign rsp.valid      = v_s4;
	assign rsp.accepted   = cmd_s4.run;
	assign rsp.irq_raised = cmd_s4.raised;

	always_comb begin
		rsp.crc_value = '0;
		if (cmd_s4.run) begin
			unique case (cmd_s4.mode)
				WM_CRC8:  rsp.crc_value = {24'h000000, crc_s4[31:24]};
				WM_CRC16: rsp.crc_value = {16'h0000, crc_s4[31:16]};
				WM_CRC32: rsp.crc_value = crc_s4;
				default:  rsp.crc_value = '0;
			endcase
		end
	end

	// a held pipeline keeps every stage occupancy
	assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s1) && $stable(v_s2) && $stable(v_s3) && $stable(v_s4))
		else $error("pipeline stage changed while stalled");

	// interrupt is only raised by a conversion that ran
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.irq_raised |-> rsp.accepted)
		else $error("interrupt raised on rejected beat");

endmodule

`default_nettype wire

@@ rtl/configurable_width_crc_engine.sv @@
// ----------------------------------------------------------------------------
// configurable_width_crc_engine
// Programmable-polynomial CRC-8/16/32 engine, msb first, no reflection.
// A request beat goes through the command queue and the four byte stages of
// the back-end pipeline. Throughput: one request beat per cycle while the
// response channel takes results; the queue decouples front and back stalls.
// Reset clears configuration, data buffer, interrupt flag, queue and valids.
// ----------------------------------------------------------------------------
`default_nettype none

module configurable_width_crc_engine #(
	parameter int QUEUE_DEPTH = crce_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	crce_req_if.sink         req,
	crce_rsp_if.source       rsp,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata
);
	import crce_pkg::*;

	cmd_t push_data;
	logic push_valid;
	logic push_ready;
	cmd_t pop_data;
	logic pop_valid;
	logic pop_ready;

	// request classification and state
	crce_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready)
	);

	// command queue
	crce_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// crc pipeline
	crce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_data  (pop_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the programmable CRC-8/16/32 engine: a short
// directed table, then random register settings with random request beats,
// random stalls on both channels, and every response checked against a typed
// value or a CRC the bench computes from its own copy of registers and state.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

	import crce_pkg::*;

	// result latency assumed by the bench for settle margins
	localparam int LAT_CYCLES = 4;
	localparam int HOLD_CYCLES = 200;
	localparam int N_PHASES = 12;
	localparam int BEATS_PER_PHASE = 140;
	localparam int N_DIR = 36;
	// index the engine does not decode
	localparam logic [1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic [31:0] crc;
		logic        acc;
		logic        irq;
	} crc_result_t;

	typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [1:0]  reg_idx;
		logic [31:0] reg_val;
		logic        func;
		logic [31:0] word;
		logic [2:0]  count;
		logic        typed;
		logic [31:0] want_crc;
		logic        want_acc;
		logic        want_irq;
	} dir_row_t;

	// directed table: register writes and request beats, expected values typed in
	// where they are plain (disabled, reserved width, zero bytes, zero polynomial)
	dir_row_t dir_tab [N_DIR] = '{
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'hFFFFFFFF, 3'd4, 1'b1, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd7, 1'b1, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_UNUSED, 32'hFFFFFFFF, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_ENABLE, 32'h1, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd0, 1'b1, 32'h0, 1'b1, 1'b1},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd4, 1'b1, 32'h0, 1'b1, 1'b0},
		'{ROW_REG, REG_POLY, 32'h07, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'h0, 3'd1, 1'b1, 32'h0, 1'b1, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'h000000FF, 3'd4, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'h12345678, 3'd5, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd6, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_WIDTH, 32'(WM_CRC16), FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd0, 1'b1, 32'hFFFF, 1'b1, 1'b1},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'hA5A5A5A5, 3'd2, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_POLY, 32'h1021, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'h31323334, 3'd4, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_WIDTH, 32'(WM_RSVD), FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'hDEADBEEF, 3'd3, 1'b1, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd4, 1'b1, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_WIDTH, 32'(WM_CRC32), FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd0, 1'b1, 32'hFFFFFFFF, 1'b1, 1'b1},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd4, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_POLY, 32'h04C11DB7, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'h0, 3'd4, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'hFFFFFFFF, 3'd7, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_POLY, 32'hFFFFFFFF, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'h80000001, 3'd4, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd1, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_ENABLE, 32'h0, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_DATA, 32'h0F0F0F0F, 3'd4, 1'b1, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_ENABLE, 32'hFFFFFFFE, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_ENABLE, 32'h1, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd4, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_WIDTH, 32'hFFFFFFFC, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_BEAT, REG_ENABLE, 32'h0, FUNC_LENGTH, 32'h0, 3'd3, 1'b0, 32'h0, 1'b0, 1'b0},
		'{ROW_REG, REG_POLY, 32'h0, FUNC_DATA, 32'h0, 3'd0, 1'b0, 32'h0, 1'b0, 1'b0}
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_wdata;

	crce_req_if req_ch ();
	crce_rsp_if rsp_ch ();

	configurable_width_crc_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_ch),
		.rsp       (rsp_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// bench copy of registers and engine state
	logic        pr_enable = 1'b0;
	width_mode_t pr_mode   = WM_CRC8;
	logic [31:0] pr_poly   = 32'h0;
	logic [31:0] pr_buffer = 32'h0;
	logic        pr_irq    = 1'b0;

	crc_result_t pending_crcs [$];

	// typed expectation riding along with the current request beat
	logic        cur_typed = 1'b0;
	crc_result_t cur_want  = '0;

	logic calm = 1'b0;
	int   hold_requests = 0;

	int n_errors = 0;
	int n_beats = 0;
	int n_results = 0;
	int n_conv = 0;
	int n_rej = 0;
	int n_irq = 0;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("timed out with %0d responses outstanding", pending_crcs.size());
		$display("configurable_width_crc_engine: mismatch");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (n_errors < 40)
			$display("%0t  %s: got %h, expected %h", $time, what, got, want);
		n_errors++;
	endtask

	// msb-first crc over the first count bytes of word, byte 0 first
	function automatic logic [31:0] crc_calc(input logic [31:0] word,
			input logic [2:0] count, input width_mode_t mode, input logic [31:0] poly);
		int          w;
		int          n;
		logic [31:0] mask;
		logic [31:0] crc;
		logic [31:0] p;
		case (mode)
			WM_CRC8: begin
				w = 8;
				crc = 32'h0;
			end
			WM_CRC16: begin
				w = 16;
				crc = 32'h0000FFFF;
			end
			default: begin
				w = 32;
				crc = 32'hFFFFFFFF;
			end
		endcase
		mask = (w == 32) ? 32'hFFFFFFFF : ((32'h1 << w) - 32'h1);
		p = poly & mask;
		n = (count > MAX_BYTES) ? int'(MAX_BYTES) : int'(count);
		for (int i = 0; i < n; i++) begin
			crc = crc ^ (((word >> (8 * i)) & 32'hFF) << (w - 8));
			for (int b = 0; b < 8; b++) begin
				if (crc[w - 1])
					crc = ((crc << 1) ^ p) & mask;
				else
					crc = (crc << 1) & mask;
			end
		end
		return crc & mask;
	endfunction

	// idle length: mostly none or short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 50);
	endfunction

	// response checking, register tracking and crc prediction per request beat
	always @(posedge clk) begin : crc_tracker
		crc_result_t want;
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				n_results++;
				if (rsp_ch.accepted === 1'b1)
					n_conv++;
				else
					n_rej++;
				if (rsp_ch.irq_raised === 1'b1)
					n_irq++;
				if (pending_crcs.size() == 0) begin
					report_mismatch("response beat with nothing outstanding",
						rsp_ch.crc_value, 32'h0);
				end else begin
					want = pending_crcs.pop_front();
					if (rsp_ch.crc_value !== want.crc)
						report_mismatch("crc_value", rsp_ch.crc_value, want.crc);
					if (rsp_ch.accepted !== want.acc)
						report_mismatch("accepted", 32'(rsp_ch.accepted), 32'(want.acc));
					if (rsp_ch.irq_raised !== want.irq)
						report_mismatch("irq_raised", 32'(rsp_ch.irq_raised), 32'(want.irq));
				end
			end
			// control writes clear the pending interrupt, polynomial writes do not
			if (cfg_we) begin
				case (cfg_index)
					REG_ENABLE: begin
						pr_enable = cfg_wdata[0];
						pr_irq = 1'b0;
					end
					REG_WIDTH: begin
						pr_mode = width_mode_t'(cfg_wdata[1:0]);
						pr_irq = 1'b0;
					end
					REG_POLY: pr_poly = cfg_wdata;
					default: ;
				endcase
			end
			if (req_ch.valid && req_ch.ready) begin
				n_beats++;
				// data writes store the word even when rejected
				if (req_ch.func == FUNC_DATA)
					pr_buffer = req_ch.data_word;
				want = '0;
				if (pr_enable && pr_mode != WM_RSVD) begin
					want.crc = crc_calc(pr_buffer, req_ch.byte_count, pr_mode, pr_poly);
					want.acc = 1'b1;
					want.irq = !pr_irq;
					pr_irq = 1'b1;
				end
				pending_crcs.push_back(cur_typed ? cur_want : want);
			end
		end
	end

	// response side: random stalls, plus long hold-offs on request
	initial begin : rsp_stall
		int hold_seen;
		int hold_left;
		int stall_left;
		hold_seen = 0;
		hold_left = 0;
		stall_left = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_seen != hold_requests) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				if (stall_left == 0)
					stall_left = pick_gap();
				if (stall_left > 0) begin
					rsp_ch.ready <= 1'b0;
					stall_left--;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// drop valid and wait until every response is back, then settle
	task automatic wait_idle(input int settle);
		if (req_ch.valid !== 1'b0)
			req_ch.valid <= 1'b0;
		while (pending_crcs.size() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		wait_idle(LAT_CYCLES + 2);
		cfg_index <= idx;
		cfg_wdata <= val;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// one request beat, then a random gap
	task automatic send_request(input logic func, input logic [31:0] word,
			input logic [2:0] count, input logic typed, input crc_result_t want);
		int gap;
		req_ch.valid <= 1'b1;
		req_ch.func <= func;
		req_ch.data_word <= word;
		req_ch.byte_count <= count;
		cur_typed <= typed;
		cur_want <= want;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// main sequence
	initial begin : main_seq
		logic        en;
		width_mode_t wm;
		logic [31:0] poly;
		logic [31:0] noise;
		logic [31:0] word;
		logic [2:0]  count;
		int          r;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ENABLE;
		cfg_wdata = 32'h0;
		req_ch.valid = 1'b0;
		req_ch.func = FUNC_DATA;
		req_ch.data_word = 32'h0;
		req_ch.byte_count = 3'd0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].kind == ROW_REG) begin
				write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
			end else begin
				send_request(dir_tab[i].func, dir_tab[i].word, dir_tab[i].count,
					dir_tab[i].typed, '{crc: dir_tab[i].want_crc, acc: dir_tab[i].want_acc,
					irq: dir_tab[i].want_irq});
			end
		end

		// random phases, one register setting each
		for (int ph = 0; ph < N_PHASES; ph++) begin
			en = 1'b1;
			case (ph)
				0: begin
					wm = WM_CRC8;
					poly = 32'h07;
				end
				1: begin
					wm = WM_CRC16;
					poly = 32'h1021;
				end
				2: begin
					wm = WM_CRC32;
					poly = 32'h04C11DB7;
				end
				3: begin
					wm = WM_CRC32;
					poly = 32'hFFFFFFFF;
				end
				4: begin
					wm = WM_CRC8;
					poly = 32'h0;
				end
				5: begin
					wm = WM_RSVD;
					poly = $urandom;
				end
				6: begin
					en = 1'b0;
					wm = WM_CRC16;
					poly = $urandom;
				end
				7: begin
					wm = WM_CRC16;
					poly = 32'hFFFFFFFF;
				end
				default: begin
					en = ($urandom_range(0, 9) != 0);
					wm = ($urandom_range(0, 9) == 0) ? WM_RSVD
						: width_mode_t'($urandom_range(0, 2));
					poly = $urandom;
				end
			endcase
			// unused upper bits of control writes now and then
			noise = ($urandom_range(0, 3) == 0) ? $urandom : 32'h0;
			write_reg(REG_POLY, poly);
			write_reg(REG_WIDTH, (noise & 32'hFFFFFFFC) | 32'(wm));
			write_reg(REG_ENABLE, (noise & 32'hFFFFFFFE) | 32'(en));
			calm = (ph == 2 || ph == 9);
			for (int k = 0; k < BEATS_PER_PHASE; k++) begin
				// long response hold-off while requests keep coming
				if (k == 40 && (ph == 1 || ph == 8))
					hold_requests++;
				// let everything drain mid-phase
				if (k == 70)
					wait_idle(0);
				r = $urandom_range(0, 19);
				case (r)
					0: word = 32'h0;
					1: word = 32'hFFFFFFFF;
					2: word = 32'h80000000;
					3: word = 32'h00000001;
					default: word = $urandom;
				endcase
				count = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7))
					: 3'($urandom_range(1, 4));
				send_request(($urandom_range(0, 1) == 0) ? FUNC_DATA : FUNC_LENGTH,
					word, count, 1'b0, '0);
			end
			calm = 1'b0;
		end

		// drain and watch for stray responses
		wait_idle(LAT_CYCLES * 4);
		$display("covered %0d request beats, %0d responses: %0d converted, %0d rejected, %0d irq",
			n_beats, n_results, n_conv, n_rej, n_irq);
		$display("settings: all width codes incl. reserved, disabled engine, polynomial extremes");
		if (n_errors == 0)
			$display("configurable_width_crc_engine: match");
		else
			$display("configurable_width_crc_engine: mismatch");
		$finish;
	end

endmodule

`default_nettype wire
